// ----- hdl/assert_macros.svh -----
// assertion macros used by the one-wire bus master rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property checked on every rising edge, suppressed while reset is low
`define OWM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("one-wire master assertion failed");

// property checked on every rising edge, reset included
`define OWM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("one-wire master assertion failed");

`else

`define OWM_ASSERT(lbl, clk, rst_n, prop)
`define OWM_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ----- hdl/owm_pkg.sv -----
// types, constants and helpers of the one-wire bus master
package owm_pkg;

    localparam int COUNT_BITS    = 10;
    localparam int BITS_PER_BYTE = 8;
    localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);
    localparam int CFG_DATA_W    = 10;
    localparam int CFG_IDX_W     = 3;

    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [BIT_IDX_W-1:0]  t_bit_idx;
    typedef logic [BITS_PER_BYTE-1:0] t_byte;

    localparam t_count   COUNT_MAX       = t_count'((1 << COUNT_BITS) - 1);
    localparam t_count   WR_ONE_REC      = t_count'(58);
    localparam t_count   WR_ZERO_REC     = t_count'(2);
    localparam t_bit_idx LAST_BIT        = t_bit_idx'(BITS_PER_BYTE - 1);

    // commands carried with a tick
    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_RESET = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_READ  = 2'd3
    } t_action;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RESET_LOW    = 3'd0,
        REG_RESET_REC    = 3'd1,
        REG_PRES_TIMEOUT = 3'd2,
        REG_PRES_MAX_LOW = 3'd3,
        REG_ONE_LOW      = 3'd4,
        REG_ZERO_LOW     = 3'd5,
        REG_READ_LOW     = 3'd6,
        REG_READ_REC     = 3'd7
    } t_cfg_idx;

    typedef enum logic [9:0] {
        PH_IDLE      = 10'b00_0000_0001,
        PH_RST_LOW   = 10'b00_0000_0010,
        PH_RST_REC   = 10'b00_0000_0100,
        PH_PRES_WAIT = 10'b00_0000_1000,
        PH_PRES_LOW  = 10'b00_0001_0000,
        PH_WR_LOW    = 10'b00_0010_0000,
        PH_WR_REC    = 10'b00_0100_0000,
        PH_RD_LOW    = 10'b00_1000_0000,
        PH_RD_SAMPLE = 10'b01_0000_0000,
        PH_RD_REC    = 10'b10_0000_0000
    } t_phase;

    typedef struct packed {
        t_action action;
        t_byte   data_byte;
        logic    line_level;
    } t_in_item;

    typedef struct packed {
        logic  drive_low;
        logic  busy_res;
        logic  done_res;
        logic  presence_ok;
        t_byte read_data;
        logic  rejected;
    } t_out_item;

    // a zero length acts as one
    function automatic t_count eff_limit(input t_count v);
        eff_limit = (v == '0) ? t_count'(1) : v;
    endfunction

endpackage

// ----- hdl/one_wire_bus_master.sv -----
// one-wire bus master: reset/presence, byte write and byte read sequencer
//
//  channel   direction   handshake                    payload
//  in        to block    i_in_valid / o_in_ready      i_in_data  (tick or command)
//  out       from block  o_out_valid / i_out_ready    o_out_data (one result per tick)
//  cfg       to block    i_cfg_we                     i_cfg_index, i_cfg_data
//
//  every transfer on the input makes exactly one result, held in the result register
//  one input transfer per clock while the result register is empty or drains; the phase
//  and tick counter update on the same input transfer that loads the result
//  a stalled result blocks only the next input transfer, not the current one
//  synchronous active-low reset: idle, line released, timing regs at defaults

module one_wire_bus_master (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  owm_pkg::t_in_item                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output owm_pkg::t_out_item                  o_out_data,
    input  logic                                i_cfg_we,
    input  logic [owm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [owm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

`include "assert_macros.svh"

    // timing registers
    owm_pkg::t_count r_reset_low;
    logic [7:0]      r_reset_rec;
    logic [7:0]      r_pres_timeout;
    owm_pkg::t_count r_pres_max_low;
    logic [7:0]      r_one_low;
    logic [7:0]      r_zero_low;
    logic [7:0]      r_read_low;
    logic [7:0]      r_read_rec;

    // sequencer state
    owm_pkg::t_phase   r_phase, n_phase;
    owm_pkg::t_count   r_tick_count, n_tick_count;
    owm_pkg::t_bit_idx r_bit_index, n_bit_index;
    owm_pkg::t_byte    r_shift_byte, n_shift_byte;
    logic              r_line_drive, n_line_drive;
    logic              r_presence, n_presence;
    owm_pkg::t_byte    r_last_read, n_last_read;
    logic              n_done;
    logic              n_rejected;

    // result register
    logic               r_out_valid;
    owm_pkg::t_out_item r_out;

    logic              in_xfer;
    owm_pkg::t_count   tc_inc;
    owm_pkg::t_count   cnt_limit;
    logic              reached;
    owm_pkg::t_byte    sampled_byte;
    logic              pres_first_fail;

    // a new tick goes in whenever the result slot is free or draining
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reset_low    <= owm_pkg::t_count'(750);
            r_reset_rec    <= 8'd15;
            r_pres_timeout <= 8'd100;
            r_pres_max_low <= owm_pkg::t_count'(240);
            r_one_low      <= 8'd8;
            r_zero_low     <= 8'd70;
            r_read_low     <= 8'd10;
            r_read_rec     <= 8'd45;
        end else if (i_cfg_we) begin
            case (owm_pkg::t_cfg_idx'(i_cfg_index))
                owm_pkg::REG_RESET_LOW:    r_reset_low    <= i_cfg_data;
                owm_pkg::REG_RESET_REC:    r_reset_rec    <= i_cfg_data[7:0];
                owm_pkg::REG_PRES_TIMEOUT: r_pres_timeout <= i_cfg_data[7:0];
                owm_pkg::REG_PRES_MAX_LOW: r_pres_max_low <= i_cfg_data;
                owm_pkg::REG_ONE_LOW:      r_one_low      <= i_cfg_data[7:0];
                owm_pkg::REG_ZERO_LOW:     r_zero_low     <= i_cfg_data[7:0];
                owm_pkg::REG_READ_LOW:     r_read_low     <= i_cfg_data[7:0];
                owm_pkg::REG_READ_REC:     r_read_rec     <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // saturating tick counter, one step per tick
    assign tc_inc = (r_tick_count == owm_pkg::COUNT_MAX) ? r_tick_count
                                                         : r_tick_count + owm_pkg::t_count'(1);

    // limit compared against in the current phase
    always_comb begin
        case (r_phase)
            owm_pkg::PH_RST_LOW:   cnt_limit = r_reset_low;
            owm_pkg::PH_RST_REC:   cnt_limit = owm_pkg::t_count'(r_reset_rec);
            owm_pkg::PH_PRES_WAIT: cnt_limit = owm_pkg::t_count'(r_pres_timeout);
            owm_pkg::PH_PRES_LOW:  cnt_limit = r_pres_max_low;
            owm_pkg::PH_WR_LOW:    cnt_limit = r_shift_byte[0] ? owm_pkg::t_count'(r_one_low)
                                                               : owm_pkg::t_count'(r_zero_low);
            owm_pkg::PH_WR_REC:    cnt_limit = r_shift_byte[0] ? owm_pkg::WR_ONE_REC
                                                               : owm_pkg::WR_ZERO_REC;
            owm_pkg::PH_RD_LOW:    cnt_limit = owm_pkg::t_count'(r_read_low);
            owm_pkg::PH_RD_REC:    cnt_limit = owm_pkg::t_count'(r_read_rec);
            default:               cnt_limit = owm_pkg::t_count'(1);
        endcase
    end

    assign reached = tc_inc >= owm_pkg::eff_limit(cnt_limit);

    // the first low presence sample already counts as one low tick
    assign pres_first_fail = owm_pkg::t_count'(1) >= owm_pkg::eff_limit(r_pres_max_low);

    // read sample merged into the byte at the current bit position
    always_comb begin
        sampled_byte = r_shift_byte;
        sampled_byte[r_bit_index] = r_shift_byte[r_bit_index] | i_in_data.line_level;
    end

    // next state for one tick
    always_comb begin
        n_phase      = r_phase;
        n_tick_count = r_tick_count;
        n_bit_index  = r_bit_index;
        n_shift_byte = r_shift_byte;
        n_line_drive = r_line_drive;
        n_presence   = r_presence;
        n_last_read  = r_last_read;
        n_done       = 1'b0;
        n_rejected   = 1'b0;

        if (r_phase == owm_pkg::PH_IDLE) begin
            // a command only launches; the line goes low at the end of this tick
            if (i_in_data.action != owm_pkg::ACT_TICK) begin
                n_tick_count = '0;
                n_bit_index  = '0;
                n_line_drive = 1'b1;
                case (i_in_data.action)
                    owm_pkg::ACT_RESET: n_phase = owm_pkg::PH_RST_LOW;
                    owm_pkg::ACT_WRITE: begin
                        n_shift_byte = i_in_data.data_byte;
                        n_phase      = owm_pkg::PH_WR_LOW;
                    end
                    default: begin
                        n_shift_byte = '0;
                        n_phase      = owm_pkg::PH_RD_LOW;
                    end
                endcase
            end
        end else begin
            // command while busy is dropped but still serves as a tick
            n_rejected = (i_in_data.action != owm_pkg::ACT_TICK);
            case (r_phase)
                owm_pkg::PH_RST_LOW: begin
                    n_tick_count = tc_inc;
                    if (reached) begin
                        n_line_drive = 1'b0;
                        n_tick_count = '0;
                        n_phase      = (r_reset_rec == '0) ? owm_pkg::PH_PRES_WAIT
                                                           : owm_pkg::PH_RST_REC;
                    end
                end
                owm_pkg::PH_RST_REC: begin
                    n_tick_count = tc_inc;
                    if (reached) begin
                        n_tick_count = '0;
                        n_phase      = owm_pkg::PH_PRES_WAIT;
                    end
                end
                owm_pkg::PH_PRES_WAIT: begin
                    if (!i_in_data.line_level) begin
                        // presence pulse starts
                        n_tick_count = owm_pkg::t_count'(1);
                        n_phase      = owm_pkg::PH_PRES_LOW;
                        if (pres_first_fail) begin
                            n_presence = 1'b0;
                            n_phase    = owm_pkg::PH_IDLE;
                            n_done     = 1'b1;
                        end
                    end else begin
                        n_tick_count = tc_inc;
                        if (reached) begin
                            // no slave answered
                            n_presence = 1'b0;
                            n_phase    = owm_pkg::PH_IDLE;
                            n_done     = 1'b1;
                        end
                    end
                end
                owm_pkg::PH_PRES_LOW: begin
                    if (i_in_data.line_level) begin
                        n_presence = 1'b1;
                        n_phase    = owm_pkg::PH_IDLE;
                        n_done     = 1'b1;
                    end else begin
                        n_tick_count = tc_inc;
                        if (reached) begin
                            // bus stuck low
                            n_presence = 1'b0;
                            n_phase    = owm_pkg::PH_IDLE;
                            n_done     = 1'b1;
                        end
                    end
                end
                owm_pkg::PH_WR_LOW: begin
                    n_tick_count = tc_inc;
                    if (reached) begin
                        n_line_drive = 1'b0;
                        n_tick_count = '0;
                        n_phase      = owm_pkg::PH_WR_REC;
                    end
                end
                owm_pkg::PH_WR_REC: begin
                    n_tick_count = tc_inc;
                    if (reached) begin
                        n_shift_byte = r_shift_byte >> 1;
                        n_tick_count = '0;
                        if (r_bit_index == owm_pkg::LAST_BIT) begin
                            n_bit_index = '0;
                            n_phase     = owm_pkg::PH_IDLE;
                            n_done      = 1'b1;
                        end else begin
                            n_bit_index  = r_bit_index + owm_pkg::t_bit_idx'(1);
                            n_line_drive = 1'b1;
                            n_phase      = owm_pkg::PH_WR_LOW;
                        end
                    end
                end
                owm_pkg::PH_RD_LOW: begin
                    n_tick_count = tc_inc;
                    if (reached) begin
                        n_line_drive = 1'b0;
                        n_tick_count = '0;
                        n_phase      = owm_pkg::PH_RD_SAMPLE;
                    end
                end
                owm_pkg::PH_RD_SAMPLE, owm_pkg::PH_RD_REC: begin
                    logic bit_end;
                    bit_end = 1'b0;
                    if (r_phase == owm_pkg::PH_RD_SAMPLE) begin
                        n_shift_byte = sampled_byte;
                        n_tick_count = '0;
                        if (r_read_rec == '0) begin
                            bit_end = 1'b1;
                        end else begin
                            n_phase = owm_pkg::PH_RD_REC;
                        end
                    end else begin
                        n_tick_count = tc_inc;
                        bit_end      = reached;
                    end
                    if (bit_end) begin
                        if (r_bit_index == owm_pkg::LAST_BIT) begin
                            n_last_read = n_shift_byte;
                            n_bit_index = '0;
                            n_phase     = owm_pkg::PH_IDLE;
                            n_done      = 1'b1;
                        end else begin
                            // open the next read slot
                            n_bit_index  = r_bit_index + owm_pkg::t_bit_idx'(1);
                            n_line_drive = 1'b1;
                            n_tick_count = '0;
                            n_phase      = owm_pkg::PH_RD_LOW;
                        end
                    end
                end
                default: begin
                    n_phase      = owm_pkg::PH_IDLE;
                    n_line_drive = 1'b0;
                end
            endcase
        end
    end

    // state update on every input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= owm_pkg::PH_IDLE;
            r_tick_count <= '0;
            r_bit_index  <= '0;
            r_shift_byte <= '0;
            r_line_drive <= 1'b0;
            r_presence   <= 1'b0;
            r_last_read  <= '0;
        end else if (in_xfer) begin
            r_phase      <= n_phase;
            r_tick_count <= n_tick_count;
            r_bit_index  <= n_bit_index;
            r_shift_byte <= n_shift_byte;
            r_line_drive <= n_line_drive;
            r_presence   <= n_presence;
            r_last_read  <= n_last_read;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out.drive_low   <= n_line_drive;
            r_out.busy_res    <= (n_phase != owm_pkg::PH_IDLE);
            r_out.done_res    <= n_done;
            r_out.presence_ok <= n_presence;
            r_out.read_data   <= n_last_read;
            r_out.rejected    <= n_rejected;
        end
    end

    // master never pulls the line while idle
    `OWM_ASSERT(a_drive_needs_busy, i_clk, i_rst_n, r_line_drive |-> (r_phase != owm_pkg::PH_IDLE))
    // bit position only advances inside a byte operation
    `OWM_ASSERT(a_bit_idx_idle, i_clk, i_rst_n, (r_bit_index != '0) |-> (r_phase != owm_pkg::PH_IDLE))
    // a finishing result never reports busy
    `OWM_ASSERT(a_done_not_busy, i_clk, i_rst_n, (r_out_valid && r_out.done_res) |-> !r_out.busy_res)
    // a launched command pulls the line low with a cleared counter
    `OWM_ASSERT(a_launch, i_clk, i_rst_n, (in_xfer && (r_phase == owm_pkg::PH_IDLE) && (i_in_data.action != owm_pkg::ACT_TICK)) |=> (r_line_drive && (r_tick_count == '0)))

endmodule
